// ----- hdl/fedm_pkg.sv -----
package fedm_pkg;

    // Longest query and candidate kept, and one systolic cell per query byte.
    localparam int MAX_LEN = 64;
    // Width of a distance, a length or a count; holds 0 .. MAX_LEN.
    localparam int DW = $clog2(MAX_LEN + 1);
    localparam int CW = 8;

    localparam logic [6:0] MAXD_RST = 7'd2;

    // Action codes carried on the input tuser.
    localparam logic [1:0] ACT_QUERY  = 2'd0;
    localparam logic [1:0] ACT_CAND   = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_WAIT_RES,
        ST_PUSH
    } state_t;

    // What one cell hands to its right neighbor each cycle.
    typedef struct packed {
        logic          wv;      // a row update wave is present
        logic [CW-1:0] ch;      // folded candidate byte
        logic [DW-1:0] dn;      // new row value of the left cell
        logic [DW-1:0] dold;    // old row value of the left cell (diagonal)
        logic          tv;      // end-of-candidate token is present
        logic [DW-1:0] res;     // distance picked up by the token so far
    } link_t;

    // Map ASCII upper case letters to lower case.
    function automatic logic [CW-1:0] fold_case(input logic [CW-1:0] c);
        logic [CW-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

// ----- hdl/fuzzy_edit_distance_match_core.sv -----
// Case-insensitive edit distance matcher. The query is loaded byte by byte
// (tuser action 0, cleared by action 3) into a row of MAX_LEN cells, one per
// query byte. Candidate bytes (action 1) are taken one per clock cycle while
// s_tready is high and sweep through the row as a skewed wavefront, one cell
// per cycle, so they may follow each other back to back. An end-of-candidate
// request (action 2) sends a token down the row behind the last byte; once
// the output register is free, the result is moved into it, and only then
// is the next request taken. A query or clear request is applied only once
// the row has drained, and the next request is taken after it is applied.
// A finished result waits in an output register while new requests are
// taken; while it is held there, the next result stalls the input.
// max_distance is written through the cfg port and resets to 2.
module fuzzy_edit_distance_match_core
    import fedm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [6:0] distance, [7] is_match, [8] overflowed
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    state_t        state_reg, state_next;
    logic [DW-1:0] qlen_reg, qlen_next;
    logic          qover_reg, qover_next;
    logic [DW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [DW-1:0] flight_reg, flight_next;
    logic [1:0]    pend_act_reg, pend_act_next;
    logic [CW-1:0] pend_char_reg, pend_char_next;
    link_t         head_reg, head_next;
    logic [DW-1:0] res_reg, res_next;
    logic [6:0]    maxd_reg;
    logic          m_valid_reg, m_valid_next;
    logic [8:0]    m_data_reg, m_data_next;

    logic          accept;
    logic          do_apply;
    logic          do_push;
    logic          restart;
    logic          out_free;
    logic          q_load;
    link_t         link [MAX_LEN+1];

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser inside {ACT_QUERY, ACT_CLEAR}) begin
                        state_next = ST_DRAIN;
                    end else if (s_tuser == ACT_END) begin
                        state_next = ST_WAIT_RES;
                    end
                end
            end
            ST_DRAIN: begin
                if (flight_reg == '0) begin
                    state_next = ST_IDLE;
                end
            end
            ST_WAIT_RES: begin
                if (link[MAX_LEN].tv) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        do_apply = (state_reg == ST_DRAIN) && (flight_reg == '0);
        do_push  = (state_reg == ST_PUSH) && out_free;
        restart  = do_apply || do_push;
        q_load   = do_apply && (pend_act_reg == ACT_QUERY);
    end

    // Datapath next values.
    always_comb begin
        qlen_next      = qlen_reg;
        qover_next     = qover_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        pend_act_next  = pend_act_reg;
        pend_char_next = pend_char_reg;
        head_next      = head_reg;
        head_next.wv   = 1'b0;
        head_next.tv   = 1'b0;
        res_next       = res_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        flight_next    = (flight_reg != '0) ? flight_reg - DW'(1) : flight_reg;

        if (accept) begin
            pend_act_next  = s_tuser;
            pend_char_next = fold_case(s_tdata);
            case (s_tuser)
                ACT_CAND: begin
                    if (count_reg >= DW'(MAX_LEN)) begin
                        ovf_next = 1'b1;
                    end else begin
                        head_next.wv   = 1'b1;
                        head_next.ch   = fold_case(s_tdata);
                        head_next.dn   = count_reg + DW'(1);
                        head_next.dold = count_reg;
                        count_next     = count_reg + DW'(1);
                        flight_next    = DW'(MAX_LEN);
                    end
                end
                ACT_END: begin
                    head_next.tv  = 1'b1;
                    head_next.res = count_reg;
                end
                default: ;
            endcase
        end

        // Query change once the row is quiet.
        if (do_apply) begin
            if (pend_act_reg == ACT_QUERY) begin
                if (qlen_reg < DW'(MAX_LEN)) begin
                    qlen_next = qlen_reg + DW'(1);
                end else begin
                    qover_next = 1'b1;
                end
            end else begin
                qlen_next  = '0;
                qover_next = 1'b0;
            end
            count_next = '0;
            ovf_next   = 1'b0;
        end

        // Token leaves the row.
        if (state_reg == ST_WAIT_RES && link[MAX_LEN].tv) begin
            res_next = link[MAX_LEN].res;
        end

        // Result into the output register.
        if (do_push) begin
            m_valid_next = 1'b1;
            m_data_next  = {ovf_reg || qover_reg,
                            (7'(res_reg) <= maxd_reg),
                            7'(res_reg)};
            count_next   = '0;
            ovf_next     = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            qlen_reg    <= '0;
            qover_reg   <= 1'b0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            flight_reg  <= '0;
            m_valid_reg <= 1'b0;
            maxd_reg    <= MAXD_RST;
        end else begin
            state_reg   <= state_next;
            qlen_reg    <= qlen_next;
            qover_reg   <= qover_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            flight_reg  <= flight_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                maxd_reg <= cfg_data;
            end
        end
    end

    // Head of the row: the request entering cell 0.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
        end else begin
            head_reg <= head_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pend_act_reg  <= pend_act_next;
        pend_char_reg <= pend_char_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    assign link[0] = head_reg;

    // Row of cells, cell k holds query byte k and row entry k + 1.
    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        fedm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .link_in  (link[k]),
            .restart  (restart),
            .init_d   (DW'(k + 1)),
            .q_we     (q_load && (qlen_reg == DW'(k))),
            .q_data   (pend_char_reg),
            .is_last  (qlen_reg == DW'(k + 1)),
            .link_out (link[k+1])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_data_reg};

endmodule

// ----- hdl/fedm_cell.sv -----
module fedm_cell
    import fedm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  link_t         link_in,
    input  logic          restart,
    input  logic [DW-1:0] init_d,
    input  logic          q_we,
    input  logic [CW-1:0] q_data,
    input  logic          is_last,
    output link_t         link_out
);

    logic [CW-1:0] q_reg;
    logic [DW-1:0] d_reg;
    link_t         out_reg;
    logic [DW-1:0] up_cost;
    logic [DW-1:0] left_cost;
    logic [DW-1:0] diag_cost;
    logic [DW-1:0] min_ab;
    logic [DW-1:0] d_next;

    // One step of the edit distance recurrence for this query position.
    always_comb begin
        up_cost   = d_reg + DW'(1);
        left_cost = link_in.dn + DW'(1);
        diag_cost = link_in.dold + ((q_reg != link_in.ch) ? DW'(1) : DW'(0));
        min_ab    = (up_cost < left_cost) ? up_cost : left_cost;
        d_next    = (diag_cost < min_ab) ? diag_cost : min_ab;
    end

    // Stored query byte.
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_reg <= q_data;
        end
    end

    // Row value held by this cell.
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            d_reg <= init_d;
        end else if (link_in.wv) begin
            d_reg <= d_next;
        end
    end

    // Valid bits and payload toward the right neighbor; the last query cell
    // inserts its value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else begin
            out_reg.wv   <= link_in.wv;
            out_reg.tv   <= link_in.tv;
            out_reg.ch   <= link_in.ch;
            out_reg.dn   <= d_next;
            out_reg.dold <= d_reg;
            out_reg.res  <= is_last ? d_reg : link_in.res;
        end
    end

    assign link_out = out_reg;

endmodule

// ----- tb/fuzzy_edit_distance_match_core_tb.sv -----
`timescale 1ns / 1ps

module fuzzy_edit_distance_match_core_tb;
    import fedm_pkg::*;

    // Idle cycles allowed after the last request before the block is surely quiet.
    localparam int DRAIN_CYCLES = MAX_LEN + 8;
    // Length of the deliberate result-side hold-off.
    localparam int LONG_HOLD    = 400;
    // Cycles without any accepted request before the run is declared hung.
    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 1300;
    localparam int PHASES       = 8;

    // Result fields in the order they sit in m_tdata, lowest bit last here.
    typedef struct packed {
        logic       overflowed;
        logic       is_match;
        logic [6:0] distance;
    } match_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [7:0] char_code
    logic [1:0]  s_tuser   = ACT_QUERY;  // [1:0] action
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // [6:0] distance, [7] is_match, [8] overflowed
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data  = '0;

    // Shadow copy of the matcher: stored query, DP row and flags.
    logic [7:0]  q_chars [MAX_LEN];
    int          q_len     = 0;
    bit          q_over    = 1'b0;
    int          dist_row [MAX_LEN + 1];
    int          cand_len  = 0;
    bit          cand_over = 1'b0;
    logic [6:0]  maxd_model = MAXD_RST;

    match_result_t pending_results [$];
    int          errors      = 0;
    int          items_sent  = 0;
    int          idle_cycles = 0;
    int          rx_hold_req = 0;
    bit          tx_burst    = 1'b0;
    bit          rx_burst    = 1'b0;

    fuzzy_edit_distance_match_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic int min_of3(input int a, input int b, input int c);
        int m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    // Back to the empty-candidate row: entry i holds i.
    function automatic void restart_row();
        for (int i = 0; i <= MAX_LEN; i++) begin
            dist_row[i] = i;
        end
        cand_len  = 0;
        cand_over = 1'b0;
    endfunction

    // Apply one accepted request to the shadow state and queue any result it causes.
    function automatic void matcher_step(input logic [1:0] act, input logic [7:0] raw);
        logic [7:0]    c;
        int            diag;
        int            above;
        int            cost;
        int            d;
        match_result_t r;
        c = lower_ascii(raw);
        case (act)
            ACT_QUERY: begin
                restart_row();
                if (q_len < MAX_LEN) begin
                    q_chars[q_len] = c;
                    q_len++;
                end else begin
                    q_over = 1'b1;
                end
            end
            ACT_CLEAR: begin
                restart_row();
                q_len  = 0;
                q_over = 1'b0;
            end
            ACT_CAND: begin
                if (cand_len >= MAX_LEN) begin
                    cand_over = 1'b1;
                end else begin
                    cand_len++;
                    diag = dist_row[0];
                    dist_row[0] = cand_len;
                    for (int i = 1; i <= q_len; i++) begin
                        above = dist_row[i];
                        cost  = (q_chars[i - 1] == c) ? 0 : 1;
                        dist_row[i] = min_of3(above + 1, dist_row[i - 1] + 1, diag + cost);
                        diag  = above;
                    end
                end
            end
            default: begin
                d = dist_row[q_len];
                if (d > 127) begin
                    d = 127;
                end
                r.distance   = 7'(d);
                r.is_match   = (d <= int'(maxd_model));
                r.overflowed = cand_over | q_over;
                pending_results = {pending_results, r};
                restart_row();
            end
        endcase
    endfunction

    // Mostly a small alphabet so that candidates often come close to the query.
    function automatic logic [7:0] rand_char();
        logic [7:0] c;
        if ($urandom_range(0, 9) < 7) begin
            c = 8'h61 + 8'($urandom_range(0, 3));
            if ($urandom_range(0, 1) == 1) begin
                c = c - 8'h20;
            end
        end else begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Offer one request after a random gap and update the shadow state once it is taken.
    task automatic send_item(input logic [1:0] act, input logic [7:0] ch);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ch;
        do @(posedge aclk); while (s_tready !== 1'b1);
        matcher_step(act, ch);
        items_sent++;
    endtask

    task automatic send_string(input logic [1:0] act, input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(act, s[i]);
        end
    endtask

    task automatic send_end();
        send_item(ACT_END, 8'($urandom_range(0, 255)));
    endtask

    // Stop offering, wait for every queued result, then let the row drain.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_distance(input logic [6:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        maxd_model = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // A candidate made from the stored query with random edits and case flips.
    task automatic send_variant();
        int         r;
        logic [7:0] c;
        for (int i = 0; i < q_len; i++) begin
            r = $urandom_range(0, 99);
            c = q_chars[i];
            if (r < 8) begin
                continue;
            end
            if (r < 16) begin
                c = rand_char();
            end else if (r < 22) begin
                send_item(ACT_CAND, rand_char());
            end
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) begin
                c = c - 8'h20;
            end
            send_item(ACT_CAND, c);
        end
        if ($urandom_range(0, 3) == 0) begin
            send_item(ACT_CAND, rand_char());
        end
        send_end();
    endtask

    // Mostly well-formed query loads and candidates, with some stray requests.
    task automatic run_random_phase(input int n);
        int stop_at;
        int r;
        int len;
        stop_at  = items_sent + n;
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                if ($urandom_range(0, 1) == 1) begin
                    send_item(ACT_CLEAR, 8'($urandom_range(0, 255)));
                end
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, MAX_LEN + 2)
                                                    : $urandom_range(0, 8);
                repeat (len) send_item(ACT_QUERY, rand_char());
            end else if (r < 80) begin
                send_variant();
            end else if (r < 88) begin
                len = ($urandom_range(0, 29) == 0) ? $urandom_range(MAX_LEN - 2, MAX_LEN + 3)
                                                    : $urandom_range(0, 10);
                repeat (len) send_item(ACT_CAND, rand_char());
                send_end();
            end else begin
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Empty query and empty candidate, then a candidate against the empty query.
    task automatic test_reset_state();
        send_item(ACT_END, 8'hFF);
        send_string(ACT_CAND, "abc");
        send_end();
    endtask

    // Substitutions, extra candidate bytes and a case-only match against a fixed query.
    task automatic test_edit_operations();
        send_item(ACT_CLEAR, 8'h00);
        send_string(ACT_QUERY, "kitten");
        send_string(ACT_CAND, "SITTING");
        send_end();
        send_string(ACT_CAND, "KitTen");
        send_end();
        send_string(ACT_CAND, "kittens");
        send_end();
    endtask

    // Bytes on both sides of the upper-case range, plus the byte extremes.
    task automatic test_case_folding();
        send_item(ACT_CLEAR, 8'hFF);
        send_item(ACT_QUERY, 8'h40);
        send_item(ACT_QUERY, 8'h41);
        send_item(ACT_QUERY, 8'h5A);
        send_item(ACT_QUERY, 8'h5B);
        send_item(ACT_QUERY, 8'h00);
        send_item(ACT_QUERY, 8'hFF);
        send_item(ACT_CAND, 8'h60);
        send_item(ACT_CAND, 8'h61);
        send_item(ACT_CAND, 8'h7A);
        send_item(ACT_CAND, 8'h7B);
        send_item(ACT_CAND, 8'h00);
        send_item(ACT_CAND, 8'hFF);
        send_end();
    endtask

    // A query byte or a clear in the middle of a candidate throws the candidate away.
    task automatic test_abandoned_candidate();
        send_item(ACT_CLEAR, 8'h00);
        send_string(ACT_QUERY, "ab");
        send_string(ACT_CAND, "x");
        send_string(ACT_QUERY, "C");
        send_string(ACT_CAND, "abc");
        send_end();
        send_string(ACT_CAND, "zz");
        send_item(ACT_CLEAR, 8'hFF);
        send_end();
    endtask

    // Query and candidate past MAX_LEN, and the largest distance at the widest threshold.
    task automatic test_long_strings();
        wait_drained();
        write_max_distance(7'd64);
        tx_burst = 1'b1;
        send_item(ACT_CLEAR, 8'h00);
        repeat (MAX_LEN + 1) send_item(ACT_QUERY, "a");
        repeat (MAX_LEN) send_item(ACT_CAND, "b");
        send_end();
        send_item(ACT_CLEAR, 8'h00);
        repeat (MAX_LEN) send_item(ACT_QUERY, "A");
        repeat (MAX_LEN + 1) send_item(ACT_CAND, "a");
        send_end();
        repeat (MAX_LEN) send_item(ACT_CAND, "B");
        send_end();
        tx_burst = 1'b0;
    endtask

    // Hold the result side off for a long time while short candidates keep coming.
    task automatic test_output_stall();
        wait_drained();
        write_max_distance(7'd1);
        tx_burst    = 1'b1;
        rx_hold_req = LONG_HOLD;
        send_item(ACT_CLEAR, 8'h00);
        send_string(ACT_QUERY, "ab");
        repeat (8) begin
            send_string(ACT_CAND, "a");
            send_end();
        end
        tx_burst = 1'b0;
        wait_drained();
    endtask

    // Random traffic in phases, with a new threshold before each one.
    task automatic test_random_traffic();
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p % 4)
                0:       write_max_distance(7'd0);
                1:       write_max_distance(7'd64);
                default: write_max_distance(7'($urandom_range(0, 64)));
            endcase
            run_random_phase(RANDOM_ITEMS / PHASES);
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        match_result_t got;
        match_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            got = m_tdata[8:0];
            if (pending_results.size() == 0) begin
                $error("result with no request waiting: m_tdata %h", m_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("distance", want.distance, got.distance);
                check_field("is_match", want.is_match, got.is_match);
                check_field("overflowed", want.overflowed, got.overflowed);
            end
        end
    end

    // Result-side ready: a random wait per result, or one long hold when asked.
    initial begin : result_sink
        int gap;
        @(posedge aresetn);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 15);
            if (rx_hold_req > 0) begin
                gap = rx_hold_req;
                rx_hold_req = 0;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1 && rx_hold_req == 0);
        end
    end

    // Give up when nothing at all is accepted for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready) ||
            (cfg_valid && cfg_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        restart_row();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_edit_operations();
        test_case_folding();
        test_abandoned_candidate();
        test_long_strings();
        test_output_stall();
        test_random_traffic();
        wait_drained();
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
